/* design/permutation_384_24_rounds_macros.svh */
// Assertion helpers shared by the permutation RTL.
`ifndef PERMUTATION_384_24_ROUNDS_MACROS_SVH
`define PERMUTATION_384_24_ROUNDS_MACROS_SVH

// Checked only while reset is low.
`define P384_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define P384_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/p384_pkg.sv */
package p384_pkg;

   localparam int WORD_W              = 32;
   localparam int WORD_COUNT          = 12;
   localparam int ROUND_COUNT_DEFAULT = 24;
   // Wide enough for any round number from 0 to 23.
   localparam int ROUND_W             = 5;
   localparam int ROT_ROW0            = 24;
   localparam int ROT_ROW1            = 9;
   localparam logic [WORD_W-1:0] ROUND_CONST = 32'h79379E00;

   // Round numbers mod 4 that trigger a swap of row 0.
   localparam logic [1:0] PHASE_SMALL_SWAP = 2'd0;
   localparam logic [1:0] PHASE_BIG_SWAP   = 2'd2;

   typedef logic [WORD_COUNT-1:0][WORD_W-1:0] state_type;

   typedef struct packed {
      logic [WORD_W-1:0] word_in_0;
      logic [WORD_W-1:0] word_in_1;
      logic [WORD_W-1:0] word_in_2;
      logic [WORD_W-1:0] word_in_3;
      logic [WORD_W-1:0] word_in_4;
      logic [WORD_W-1:0] word_in_5;
      logic [WORD_W-1:0] word_in_6;
      logic [WORD_W-1:0] word_in_7;
      logic [WORD_W-1:0] word_in_8;
      logic [WORD_W-1:0] word_in_9;
      logic [WORD_W-1:0] word_in_10;
      logic [WORD_W-1:0] word_in_11;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] word_out_0;
      logic [WORD_W-1:0] word_out_1;
      logic [WORD_W-1:0] word_out_2;
      logic [WORD_W-1:0] word_out_3;
      logic [WORD_W-1:0] word_out_4;
      logic [WORD_W-1:0] word_out_5;
      logic [WORD_W-1:0] word_out_6;
      logic [WORD_W-1:0] word_out_7;
      logic [WORD_W-1:0] word_out_8;
      logic [WORD_W-1:0] word_out_9;
      logic [WORD_W-1:0] word_out_10;
      logic [WORD_W-1:0] word_out_11;
   } rsp_type;

endpackage

/* design/permutation_384_24_rounds.sv */
// 384-bit Gimli-style permutation with rounds numbered upward from 0. Each of the
// ROUND_COUNT rounds has its own register stage, so one beat can enter every cycle
// while req_stall is low, and a result passes through the round stages in order.
// A stalled output holds its beat in the last stage while empty stages further up
// keep filling; req_stall rises only when every stage holds a beat and the output
// is stalled.
module permutation_384_24_rounds
   import p384_pkg::*;
#(
   parameter int ROUND_COUNT = ROUND_COUNT_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   `include "permutation_384_24_rounds_macros.svh"

   logic      stage_valid [ROUND_COUNT+1];
   logic      stage_ready [ROUND_COUNT+1];
   state_type state       [ROUND_COUNT+1];

   // Input and output beats map word for word onto the state vector.
   assign state[0] = {req_data.word_in_11, req_data.word_in_10, req_data.word_in_9,
                      req_data.word_in_8,  req_data.word_in_7,  req_data.word_in_6,
                      req_data.word_in_5,  req_data.word_in_4,  req_data.word_in_3,
                      req_data.word_in_2,  req_data.word_in_1,  req_data.word_in_0};

   always_comb begin
      rsp_data.word_out_0  = state[ROUND_COUNT][0];
      rsp_data.word_out_1  = state[ROUND_COUNT][1];
      rsp_data.word_out_2  = state[ROUND_COUNT][2];
      rsp_data.word_out_3  = state[ROUND_COUNT][3];
      rsp_data.word_out_4  = state[ROUND_COUNT][4];
      rsp_data.word_out_5  = state[ROUND_COUNT][5];
      rsp_data.word_out_6  = state[ROUND_COUNT][6];
      rsp_data.word_out_7  = state[ROUND_COUNT][7];
      rsp_data.word_out_8  = state[ROUND_COUNT][8];
      rsp_data.word_out_9  = state[ROUND_COUNT][9];
      rsp_data.word_out_10 = state[ROUND_COUNT][10];
      rsp_data.word_out_11 = state[ROUND_COUNT][11];
   end

   // Channel ends of the stage chain.
   assign stage_valid[0]           = req_valid;
   assign req_stall                = !stage_ready[0];
   assign stage_ready[ROUND_COUNT] = !rsp_stall;
   assign rsp_valid                = stage_valid[ROUND_COUNT];

   // One register stage per round.
   for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_round
      p384_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .round_idx (ROUND_W'(i)),
         .up_valid  (stage_valid[i]),
         .up_ready  (stage_ready[i]),
         .up_state  (state[i]),
         .dn_valid  (stage_valid[i+1]),
         .dn_ready  (stage_ready[i+1]),
         .dn_state  (state[i+1])
      );
   end

   // An accepted beat always lands in the first stage.
   `P384_ASSERT(a_enter_first, clock, reset,
      req_valid && !req_stall |=> stage_valid[1], "accepted beat missing from first stage")
   // Input stalls only when the whole pipe is full and the output is stalled.
   `P384_ASSERT(a_stall_full, clock, reset,
      req_stall |-> rsp_valid && rsp_stall, "input stalled with room in the pipe")
   // A held first stage keeps its beat when the next stage cannot take it.
   `P384_ASSERT(a_first_holds, clock, reset,
      stage_valid[1] && !stage_ready[1] |=> stage_valid[1], "beat lost from a held stage")
   // Reset empties the pipe.
   `P384_ASSERT_ALWAYS(a_reset_empty, clock,
      reset |=> !rsp_valid, "result valid right after reset")

endmodule

/* design/p384_stage.sv */
module p384_stage
   import p384_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [ROUND_W-1:0]  round_idx,
   input  logic                up_valid,
   output logic                up_ready,
   input  state_type           up_state,
   output logic                dn_valid,
   input  logic                dn_ready,
   output state_type           dn_state
);

   logic      valid_ff;
   logic      valid_in;
   state_type state_ff;
   state_type state_in;

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int k);
      rotl = (v << k) | (v >> (WORD_W - k));
   endfunction

   // One round: column mix on all four columns, then the row 0 shuffle on rounds 0 and 2 mod 4.
   always_comb begin
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] z;
      state_type mixed;
      mixed = up_state;
      for (int c = 0; c < 4; c++) begin
         x = rotl(up_state[c], ROT_ROW0);
         y = rotl(up_state[c+4], ROT_ROW1);
         z = up_state[c+8];
         mixed[c]   = z ^ y ^ ((x & y) << 3);
         mixed[c+4] = y ^ x ^ ((x | z) << 1);
         mixed[c+8] = x ^ (z << 1) ^ ((y & z) << 2);
      end
      state_in = mixed;
      case (round_idx[1:0])
         PHASE_SMALL_SWAP: begin
            state_in[0] = mixed[1] ^ ROUND_CONST ^ WORD_W'(round_idx);
            state_in[1] = mixed[0];
            state_in[2] = mixed[3];
            state_in[3] = mixed[2];
         end
         PHASE_BIG_SWAP: begin
            state_in[0] = mixed[2];
            state_in[1] = mixed[3];
            state_in[2] = mixed[0];
            state_in[3] = mixed[1];
         end
         default: begin
         end
      endcase
   end

   // The stage takes a beat when empty or when its own beat moves on.
   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload loads only on an accepted beat.
   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         state_ff <= state_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_state = state_ff;

endmodule
